### hdl/gda_pkg.sv
// Shared types, widths and calendar constants for the Gregorian date adder.
// Depends on nothing; every other file takes it by scoped names.

package gda_pkg;

    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int YEAR_W  = 14;
    localparam int END_W   = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 14;

    // y / 25 == (y * RECIP_25) >> RECIP_SHIFT for every 14-bit y
    localparam int RECIP_W     = 13;
    localparam int RECIP_SHIFT = 17;
    localparam logic [RECIP_W-1:0] RECIP_25 = 13'd5243;
    localparam int QUOT_W = 10;
    localparam int REM_W  = 5;
    localparam logic [REM_W-1:0] REM_LAST = 5'd24;

    localparam logic [YEAR_W-1:0]  YEAR_MAX  = 14'h3FFF;
    localparam logic [MONTH_W-1:0] MONTH_MAX = 4'd12;
    localparam logic [END_W-1:0]   LEN_COMMON = 9'd365;
    localparam logic [END_W-1:0]   LEN_LEAP   = 9'd366;

    localparam logic [MONTH_W-1:0] RESET_MONTH = 4'd1;
    localparam logic [DAY_W-1:0]   RESET_DAY   = 5'd1;
    localparam logic [YEAR_W-1:0]  RESET_YEAR  = 14'd2000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_MONTH = 2'd0,
        CFG_START_DAY   = 2'd1,
        CFG_START_YEAR  = 2'd2
    } cfg_idx_t;

    typedef logic [END_W-1:0] ends_t [13];

    localparam ends_t COMMON_ENDS = '{9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
                                      9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365};
    localparam ends_t LEAP_ENDS   = '{9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152, 9'd182,
                                      9'd213, 9'd244, 9'd274, 9'd305, 9'd335, 9'd366};

    // Controller to datapath
    typedef struct packed {
        logic load;       // capture offset and start date
        logic div_step;   // year / 25
        logic rem_step;   // year mod 25
        logic doy;        // day of year plus offset
        logic year_step;  // remove one year
        logic emit;       // month search, load result register
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic year_done;  // running count fits in current year
    } sts_t;

    // Leap when divisible by 4, except centuries not divisible by 400.
    // Century test: year mod 25 == 0 together with year mod 4 == 0.
    function automatic logic is_leap(input logic [3:0] year_lo, input logic [REM_W-1:0] rem25);
        logic by4;
        by4 = (year_lo[1:0] == 2'b00);
        return by4 && ((rem25 != '0) || (year_lo == 4'b0000));
    endfunction

    function automatic logic [END_W-1:0] month_end(input logic leap, input logic [3:0] idx);
        logic [END_W-1:0] val;
        val = '0;
        if (idx <= 4'd12)
            val = leap ? LEAP_ENDS[idx] : COMMON_ENDS[idx];
        return val;
    endfunction

endpackage

### hdl/gda_if.sv
// Handshake channel interfaces for the Gregorian date adder.
// Depends on gda_pkg for field widths.

interface gda_in_if #(
    parameter int OFFSET_BITS = 20
);
    logic                   valid;
    logic                   ready;
    logic [OFFSET_BITS-1:0] day_offset;

    modport source (output valid, output day_offset, input ready);
    modport sink   (input valid, input day_offset, output ready);
endinterface

interface gda_out_if;
    logic                          valid;
    logic                          ready;
    logic [gda_pkg::MONTH_W-1:0]   result_month;
    logic [gda_pkg::DAY_W-1:0]     result_day;
    logic [gda_pkg::YEAR_W-1:0]    result_year;

    modport source (output valid, output result_month, output result_day,
                    output result_year, input ready);
    modport sink   (input valid, input result_month, input result_day,
                    input result_year, output ready);
endinterface

### hdl/gda_ctrl.sv
// Sequencer for the Gregorian date adder: issues datapath commands, owns the
// handshake flags. Depends on gda_pkg.

module gda_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    output gda_pkg::cmd_t   cmd,
    input  gda_pkg::sts_t   sts
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_DIV   = 6'b000010,
        ST_REM   = 6'b000100,
        ST_DOY   = 6'b001000,
        ST_YEAR  = 6'b010000,
        ST_MONTH = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                state_next   = ST_REM;
            end
            ST_REM:
            begin
                cmd.rem_step = 1'b1;
                state_next   = ST_DOY;
            end
            ST_DOY:
            begin
                cmd.doy    = 1'b1;
                state_next = ST_YEAR;
            end
            ST_YEAR:
            begin
                if (sts.year_done)
                    state_next = ST_MONTH;
                else
                    cmd.year_step = 1'b1;
            end
            ST_MONTH:
            begin
                // wait for the result register to drain
                if (!out_valid_reg || out_ready)
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

### hdl/gda_dp.sv
// Datapath for the Gregorian date adder: start-date registers, year counter
// with mod-25 tracking, day count, month search and result register.
// Depends on gda_pkg.

module gda_dp #(
    parameter int OFFSET_BITS = 20
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [gda_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [gda_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic [OFFSET_BITS-1:0]            day_offset,
    input  gda_pkg::cmd_t                     cmd,
    output gda_pkg::sts_t                     sts,
    output logic [gda_pkg::MONTH_W-1:0]       result_month,
    output logic [gda_pkg::DAY_W-1:0]         result_day,
    output logic [gda_pkg::YEAR_W-1:0]        result_year
);

    localparam int LEFT_W = OFFSET_BITS + 1;
    localparam int PROD_W = gda_pkg::YEAR_W + gda_pkg::RECIP_W;

    // configuration
    logic [gda_pkg::MONTH_W-1:0] start_month_reg;
    logic [gda_pkg::DAY_W-1:0]   start_day_reg;
    logic [gda_pkg::YEAR_W-1:0]  start_year_reg;

    // working registers
    logic [OFFSET_BITS-1:0]       offset_reg;
    logic [3:0]                   mon_idx_reg;
    logic [gda_pkg::DAY_W-1:0]    day_reg;
    logic [gda_pkg::YEAR_W-1:0]   year_reg;
    logic [gda_pkg::QUOT_W-1:0]   quot_reg;
    logic [gda_pkg::REM_W-1:0]    rem25_reg;
    logic [LEFT_W-1:0]            left_reg;
    logic [gda_pkg::MONTH_W-1:0]  res_month_reg;
    logic [gda_pkg::DAY_W-1:0]    res_day_reg;
    logic [gda_pkg::YEAR_W-1:0]   res_year_reg;

    logic [3:0]                   mon_idx_next;
    logic [gda_pkg::DAY_W-1:0]    day_next;
    logic [PROD_W-1:0]            prod;
    logic [gda_pkg::YEAR_W:0]     quot_x25;
    logic [gda_pkg::YEAR_W:0]     rem_full;
    logic                         leap;
    logic [gda_pkg::END_W-1:0]    year_len;
    logic [gda_pkg::END_W-1:0]    doy_base;
    logic [3:0]                   sel_mon;
    logic [gda_pkg::END_W-1:0]    prev_end;
    logic [LEFT_W-1:0]            day_full;
    logic [gda_pkg::REM_W-1:0]    rem25_inc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_month_reg <= gda_pkg::RESET_MONTH;
            start_day_reg   <= gda_pkg::RESET_DAY;
            start_year_reg  <= gda_pkg::RESET_YEAR;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                gda_pkg::CFG_START_MONTH: start_month_reg <= cfg_wdata[gda_pkg::MONTH_W-1:0];
                gda_pkg::CFG_START_DAY:   start_day_reg   <= cfg_wdata[gda_pkg::DAY_W-1:0];
                gda_pkg::CFG_START_YEAR:  start_year_reg  <= cfg_wdata[gda_pkg::YEAR_W-1:0];
                default: ;
            endcase
        end
    end

    // clamp month to 1..12 (kept as 0..11), day zero reads as 1
    always_comb
    begin
        if (start_month_reg == '0)
            mon_idx_next = 4'd0;
        else if (start_month_reg > gda_pkg::MONTH_MAX)
            mon_idx_next = 4'd11;
        else
            mon_idx_next = start_month_reg - 4'd1;
        day_next = (start_day_reg == '0) ? gda_pkg::DAY_W'(1) : start_day_reg;
    end

    assign prod     = PROD_W'(year_reg) * PROD_W'(gda_pkg::RECIP_25);
    assign quot_x25 = {1'b0, quot_reg, 4'b0} + {2'b0, quot_reg, 3'b0} + {5'b0, quot_reg};
    assign rem_full = {1'b0, year_reg} - quot_x25;

    assign leap      = gda_pkg::is_leap(year_reg[3:0], rem25_reg);
    assign year_len  = leap ? gda_pkg::LEN_LEAP : gda_pkg::LEN_COMMON;
    assign doy_base  = gda_pkg::month_end(leap, mon_idx_reg);
    assign sts.year_done = (left_reg <= LEFT_W'(year_len));
    assign rem25_inc = (rem25_reg == gda_pkg::REM_LAST) ? '0 : rem25_reg + 1'b1;

    // month = first month whose end is not below the count
    always_comb
    begin
        sel_mon = 4'd1;
        for (int i = 1; i < 12; i++)
        begin
            if (LEFT_W'(gda_pkg::month_end(leap, 4'(i))) < left_reg)
                sel_mon = 4'(i + 1);
        end
        prev_end = gda_pkg::month_end(leap, sel_mon - 4'd1);
        day_full = left_reg - LEFT_W'(prev_end);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            offset_reg  <= day_offset;
            mon_idx_reg <= mon_idx_next;
            day_reg     <= day_next;
            year_reg    <= start_year_reg;
        end
        if (cmd.div_step)
            quot_reg <= prod[PROD_W-1:gda_pkg::RECIP_SHIFT];
        if (cmd.rem_step)
            rem25_reg <= rem_full[gda_pkg::REM_W-1:0];
        if (cmd.doy)
            left_reg <= LEFT_W'(doy_base) + LEFT_W'(day_reg) + LEFT_W'(offset_reg);
        if (cmd.year_step)
        begin
            left_reg  <= left_reg - LEFT_W'(year_len);
            year_reg  <= year_reg + 1'b1;
            // counter wraps to year zero, which is a multiple of 25
            rem25_reg <= (year_reg == gda_pkg::YEAR_MAX) ? '0 : rem25_inc;
        end
        if (cmd.emit)
        begin
            res_month_reg <= sel_mon;
            res_day_reg   <= day_full[gda_pkg::DAY_W-1:0];
            res_year_reg  <= year_reg;
        end
    end

    assign result_month = res_month_reg;
    assign result_day   = res_day_reg;
    assign result_year  = res_year_reg;

endmodule

### hdl/gregorian_date_add_days.sv
// Top level of the Gregorian date adder: controller plus datapath.
// Depends on gda_pkg, gda_if, gda_ctrl and gda_dp.
//
//   channel     dir  payload                                     handshake
//   offset_ch   in   day_offset[OFFSET_BITS-1:0]                 valid/ready
//   date_ch     out  result_month[3:0] result_day[4:0]           valid/ready
//                    result_year[13:0]
//   cfg_*       in   cfg_index[1:0] cfg_wdata[13:0]              cfg_we, no back-pressure
//
// Sequence: an offset accepted in idle goes through three setup steps (year/25, year mod
// 25, day of year), then the year loop, which makes one 365/366 subtraction per cycle until
// the count fits the current year, once for each of the N whole years crossed (roughly
// offset/365, up to about 2900 at 20 bits), and last the month search.
// Reset: start date returns to January 1, 2000; nothing in flight.
// Stalls: the result register holds while date_ch.ready is low; a new offset
// is still taken, and its result waits in the month stage until it drains.

module gregorian_date_add_days #(
    parameter int OFFSET_BITS = 20
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [gda_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gda_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    gda_in_if.sink                          offset_ch,
    gda_out_if.source                       date_ch
);

    gda_pkg::cmd_t cmd;   // sequencer commands
    gda_pkg::sts_t sts;   // year-loop status
    logic          in_ready;
    logic          out_valid;

    // sequencer: owns the state and the result-valid flag
    gda_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (offset_ch.valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (date_ch.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    // datapath: start date, year counter, day count and result register
    gda_dp #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .day_offset   (offset_ch.day_offset),
        .cmd          (cmd),
        .sts          (sts),
        .result_month (date_ch.result_month),
        .result_day   (date_ch.result_day),
        .result_year  (date_ch.result_year)
    );

    assign offset_ch.ready = in_ready;
    assign date_ch.valid   = out_valid;

endmodule

### hdl/gda_checker.sv
// Port-level checks for the Gregorian date adder, bound to the top level.
// Depends on gda_pkg and gregorian_date_add_days.

module gda_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [gda_pkg::MONTH_W-1:0]   result_month,
    input logic [gda_pkg::DAY_W-1:0]     result_day,
    input logic [gda_pkg::YEAR_W-1:0]    result_year
);

    // a stalled result transaction holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_month)
            && $stable(result_day) && $stable(result_year))
        else $error("result changed while stalled");

    // one transaction at a time: busy right after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("accepted a second offset while busy");

    // no result can appear the cycle after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("result too early");

    // results have a month in 1..12 and a nonzero day
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> result_month != '0 && result_month <= gda_pkg::MONTH_MAX
            && result_day != '0)
        else $error("result month or day out of range");

endmodule

bind gregorian_date_add_days gda_checker u_gda_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (offset_ch.valid),
    .in_ready     (offset_ch.ready),
    .out_valid    (date_ch.valid),
    .out_ready    (date_ch.ready),
    .result_month (date_ch.result_month),
    .result_day   (date_ch.result_day),
    .result_year  (date_ch.result_year)
);
